>>> design/pnebt_pkg.sv
// ----------------------------------------------------------------------------
// Per-node energy budget tracker package
// Shared types, field widths, operation and status codes, and register
// indexes for the energy budget tracker.
// ----------------------------------------------------------------------------
package pnebt_pkg;

    localparam int NODE_ID_W   = 6;
    localparam int ENERGY_W    = 40;
    localparam int COST_W      = 16;
    localparam int PRODUCT_W   = 2 * COST_W;
    localparam int TOTAL_W     = 48;
    localparam int TALLY_W     = 7;
    localparam int CFG_INDEX_W = 2;

    localparam int NODES_DEFAULT = 64;

    localparam logic [1:0] OP_TX      = 2'd0;
    localparam logic [1:0] OP_RX      = 2'd1;
    localparam logic [1:0] OP_INSTALL = 2'd2;

    localparam logic [1:0] STATUS_CHARGED   = 2'd0;
    localparam logic [1:0] STATUS_DRAINED   = 2'd1;
    localparam logic [1:0] STATUS_IGNORED   = 2'd2;
    localparam logic [1:0] STATUS_INSTALLED = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_ENERGY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TX_COST        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_COST        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL_BYTES  = 2'd3;

    localparam logic [ENERGY_W-1:0] INITIAL_ENERGY_RESET = 40'd1000000000;
    localparam logic [COST_W-1:0]   TX_COST_RESET        = 16'd6000;
    localparam logic [COST_W-1:0]   RX_COST_RESET        = 16'd6000;
    localparam logic [COST_W-1:0]   NOMINAL_BYTES_RESET  = 16'd512;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [1:0]           op;
        logic [NODE_ID_W-1:0] node_id;
        logic [COST_W-1:0]    packet_bytes;
        logic                 node_is_sink;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ENERGY_W-1:0]  remaining;
        logic [1:0]           level;
        logic                 can_send;
        logic                 stop_request;
        logic [TALLY_W-1:0]   drained_count;
        logic [NODE_ID_W-1:0] first_drained_node;
        logic                 any_drained;
        logic [TOTAL_W-1:0]   total_consumed;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic multiply;
        logic decide;
        logic update;
        logic load;
    } cmd_t;

endpackage

>>> design/pnebt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pnebt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/pnebt_ctrl.sv
// ----------------------------------------------------------------------------
// Energy budget tracker controller
// Sequences one request through read, multiply, decide, update and result
// load, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module pnebt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pnebt_pkg::cmd_t cmd
);

    import pnebt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.multiply = 1'b1;
                state_next   = S_DEC;
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_MUL)
        else $error("accepted request did not start the sequence");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_OUT)
        else $error("result appeared outside the output step");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && rsp_valid && rsp_stall |=> state_reg == S_OUT)
        else $error("result overwritten while the previous one waits");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

>>> design/pnebt_dp.sv
// ----------------------------------------------------------------------------
// Energy budget tracker datapath
// Configuration registers, the per-node budget memory and active flags,
// the charge arithmetic, drain bookkeeping and the result register.
// ----------------------------------------------------------------------------
module pnebt_dp #(
    parameter int NODES = pnebt_pkg::NODES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pnebt_pkg::cmd_t                   cmd,
    input  pnebt_pkg::req_t                   req,
    input  logic                              cfg_we,
    input  logic [pnebt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pnebt_pkg::ENERGY_W-1:0]    cfg_data,
    output pnebt_pkg::rsp_t                   rsp
);

    import pnebt_pkg::*;

    localparam int MaxIds  = 2 ** NODE_ID_W;
    localparam int Depth   = (NODES < MaxIds) ? NODES : MaxIds;
    localparam int AddrW   = $clog2(Depth);
    localparam int IdCmpW  = NODE_ID_W + 1;
    localparam int ScaledW = ENERGY_W + 4;

    logic [ENERGY_W-1:0] init_energy_reg;
    logic [COST_W-1:0]   tx_cost_reg;
    logic [COST_W-1:0]   rx_cost_reg;
    logic [COST_W-1:0]   nominal_reg;

    req_t                req_reg;
    logic [AddrW-1:0]    addr_reg;
    logic                in_range_reg;
    logic                active_hit_reg;
    logic [Depth-1:0]    node_active_reg;

    logic [ENERGY_W-1:0] ram_rdata;
    logic [ENERGY_W-1:0] old_reg;
    logic [PRODUCT_W-1:0] cost_reg;
    logic [PRODUCT_W-1:0] thresh_reg;
    logic [PRODUCT_W-1:0] tx_need_reg;

    logic [1:0]          status_reg;
    logic [ENERGY_W-1:0] rem_reg;
    logic [ENERGY_W-1:0] add_reg;
    logic                write_reg;
    logic                drain_reg;
    logic                stop_reg;

    logic [ScaledW-1:0]  rem10_reg;
    logic [ScaledW-1:0]  init9_reg;
    logic                can_send_reg;

    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [TALLY_W-1:0]   tally_reg;
    logic [NODE_ID_W-1:0] first_reg;
    logic                 seen_reg;

    rsp_t                rsp_reg;

    logic                 in_range;
    logic [AddrW-1:0]     addr;
    logic [COST_W-1:0]    rate;
    logic [PRODUCT_W:0]   limit;
    logic                 drain;
    logic [1:0]           status_next;
    logic [ENERGY_W-1:0]  rem_next;
    logic [ENERGY_W-1:0]  add_next;
    logic                 write_next;
    logic [TOTAL_W:0]     total_sum;
    logic [1:0]           level;

    assign addr     = req.node_id[AddrW-1:0];
    assign in_range = {1'b0, req.node_id} < IdCmpW'(Depth);
    assign rate     = (req_reg.op == OP_TX) ? tx_cost_reg : rx_cost_reg;

    pnebt_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (Depth)
    ) u_budget_ram (
        .clk   (clk),
        .we    (cmd.update && write_reg),
        .waddr (addr_reg),
        .wdata (rem_reg),
        .re    (cmd.capture),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_energy_reg <= INITIAL_ENERGY_RESET;
            tx_cost_reg     <= TX_COST_RESET;
            rx_cost_reg     <= RX_COST_RESET;
            nominal_reg     <= NOMINAL_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INITIAL_ENERGY: init_energy_reg <= cfg_data;
                CFG_TX_COST:        tx_cost_reg     <= cfg_data[COST_W-1:0];
                CFG_RX_COST:        rx_cost_reg     <= cfg_data[COST_W-1:0];
                CFG_NOMINAL_BYTES:  nominal_reg     <= cfg_data[COST_W-1:0];
                default:            ;
            endcase
        end
    end

    // Request capture and multiply step; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg        <= req;
            addr_reg       <= addr;
            in_range_reg   <= in_range;
            active_hit_reg <= in_range && node_active_reg[addr];
        end
        if (cmd.multiply)
        begin
            old_reg     <= active_hit_reg ? ram_rdata : '0;
            cost_reg    <= PRODUCT_W'(req_reg.packet_bytes) * PRODUCT_W'(rate);
            thresh_reg  <= PRODUCT_W'(nominal_reg) * PRODUCT_W'(rate);
            tx_need_reg <= PRODUCT_W'(req_reg.packet_bytes) * PRODUCT_W'(tx_cost_reg);
        end
    end

    assign limit = {1'b0, cost_reg} + {1'b0, thresh_reg};
    assign drain = old_reg <= ENERGY_W'(limit);

    always_comb
    begin
        status_next = STATUS_IGNORED;
        rem_next    = old_reg;
        add_next    = '0;
        write_next  = 1'b0;
        if (!in_range_reg)
        begin
            rem_next = '0;
        end
        else if (req_reg.op == OP_INSTALL)
        begin
            status_next = STATUS_INSTALLED;
            rem_next    = init_energy_reg;
            write_next  = 1'b1;
        end
        else if ((req_reg.op == OP_TX || req_reg.op == OP_RX) && active_hit_reg)
        begin
            write_next = 1'b1;
            if (drain)
            begin
                status_next = STATUS_DRAINED;
                rem_next    = '0;
                add_next    = old_reg;
            end
            else
            begin
                status_next = STATUS_CHARGED;
                rem_next    = old_reg - ENERGY_W'(cost_reg);
                add_next    = ENERGY_W'(cost_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            status_reg <= status_next;
            rem_reg    <= rem_next;
            add_reg    <= add_next;
            write_reg  <= write_next;
            drain_reg  <= (status_next == STATUS_DRAINED);
            stop_reg   <= (status_next == STATUS_DRAINED) && req_reg.node_is_sink;
        end
        if (cmd.update)
        begin
            rem10_reg    <= {rem_reg, 3'b000} + {2'b00, rem_reg, 1'b0};
            init9_reg    <= {1'b0, init_energy_reg, 3'b000} + {4'b0000, init_energy_reg};
            can_send_reg <= rem_reg >= ENERGY_W'(tx_need_reg);
        end
    end

    assign total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(add_reg);
    assign total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_active_reg <= '0;
            total_reg       <= '0;
            tally_reg       <= '0;
            first_reg       <= '0;
            seen_reg        <= 1'b0;
        end
        else if (cmd.update)
        begin
            total_reg <= total_next;
            if (status_reg == STATUS_INSTALLED)
            begin
                node_active_reg[addr_reg] <= 1'b1;
            end
            if (drain_reg)
            begin
                node_active_reg[addr_reg] <= 1'b0;
                if (tally_reg != TALLY_MAX)
                begin
                    tally_reg <= tally_reg + TALLY_W'(1);
                end
                if (!seen_reg)
                begin
                    seen_reg  <= 1'b1;
                    first_reg <= req_reg.node_id;
                end
            end
        end
    end

    always_comb
    begin
        priority if (rem10_reg >= init9_reg)
        begin
            level = 2'd3;
        end
        else if ({3'b000, rem_reg, 1'b0} >= {4'b0000, init_energy_reg})
        begin
            level = 2'd2;
        end
        else if ({2'b00, rem_reg, 2'b00} >= {4'b0000, init_energy_reg})
        begin
            level = 2'd1;
        end
        else
        begin
            level = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg.status             <= status_reg;
            rsp_reg.remaining          <= rem_reg;
            rsp_reg.level              <= level;
            rsp_reg.can_send           <= can_send_reg;
            rsp_reg.stop_request       <= stop_reg;
            rsp_reg.drained_count      <= tally_reg;
            rsp_reg.first_drained_node <= first_reg;
            rsp_reg.any_drained        <= seen_reg;
            rsp_reg.total_consumed     <= total_reg;
        end
    end

    assign rsp = rsp_reg;

`ifndef ASSERT_OFF
    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg >= $past(tally_reg))
        else $error("drain count decreased");

    a_seen_with_tally: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> tally_reg != '0)
        else $error("drain recorded without a drain count");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg))
        else $error("consumed energy total decreased");
`endif

endmodule

>>> design/per_node_energy_budget_tracker_unit.sv
// ----------------------------------------------------------------------------
// Per-node energy budget tracker
// Keeps a budget for each node, charges transmit and receive energy, detects
// drained nodes and reports the energy level with each result.
//
//   Channel   Handshake          Payload
//   req       req_valid/stall    pnebt_pkg::req_t (op, node, bytes, sink)
//   rsp       rsp_valid/stall    pnebt_pkg::rsp_t (status, budget, counters)
//   cfg       cfg_valid/ready    cfg_index, cfg_data
//
// The acceptance edge starts the memory read, followed by multiply, drain
// decision and update; the result is loaded with the level compare in the
// output step once the output register is free, and a new request is
// accepted only after that load.
// Reset clears the node active flags at once, so no clearing pass is needed.
// A finished result waits in the output register while the next request runs;
// only the final step waits for that register to drain.
// ----------------------------------------------------------------------------
module per_node_energy_budget_tracker_unit #(
    parameter int NODES = pnebt_pkg::NODES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  pnebt_pkg::req_t                   req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output pnebt_pkg::rsp_t                   rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pnebt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pnebt_pkg::ENERGY_W-1:0]    cfg_data
);

    import pnebt_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    pnebt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    pnebt_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

>>> tb/sv/tb_per_node_energy_budget_tracker_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the per-node energy budget tracker
// Drives install, transmit, receive and unused-op requests on the request channel
// under random idling on both sides. A ledger class tracks every node budget,
// the drain counters and the consumed total, and predicts each result, which
// is then checked field by field in order. The run steps through several
// register settings, from all zero to all ones. It ends by pushing the
// drain count into saturation.
// ----------------------------------------------------------------------------
module tb_per_node_energy_budget_tracker_unit;
    import pnebt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] LEVEL_LOW     = 2'd0;
    localparam logic [1:0] LEVEL_QUARTER = 2'd1;
    localparam logic [1:0] LEVEL_HALF    = 2'd2;
    localparam logic [1:0] LEVEL_HIGH    = 2'd3;

    localparam int NODE_COUNT    = NODES_DEFAULT;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 25;
    localparam int SATURATED_RUN = 8;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [COST_W-1:0]   COST_MAX   = '1;

    class budget_ledger;
        logic [ENERGY_W-1:0]  budget [NODE_COUNT];
        bit                   live [NODE_COUNT];
        logic [TOTAL_W-1:0]   energy_total;
        logic [TALLY_W-1:0]   drain_tally;
        logic [NODE_ID_W-1:0] first_drain;
        bit                   drain_seen;
        logic [ENERGY_W-1:0]  init_energy;
        logic [COST_W-1:0]    tx_rate;
        logic [COST_W-1:0]    rx_rate;
        logic [COST_W-1:0]    nominal_bytes;
        rsp_t                 due_reports [$];
        int                   errors;

        function new();
            foreach (budget[i])
            begin
                budget[i] = '0;
                live[i]   = 1'b0;
            end
            energy_total  = '0;
            drain_tally   = '0;
            first_drain   = '0;
            drain_seen    = 1'b0;
            init_energy   = INITIAL_ENERGY_RESET;
            tx_rate       = TX_COST_RESET;
            rx_rate       = RX_COST_RESET;
            nominal_bytes = NOMINAL_BYTES_RESET;
            errors        = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [ENERGY_W-1:0] value);
            case (index)
                CFG_INITIAL_ENERGY: init_energy   = value;
                CFG_TX_COST:        tx_rate       = value[COST_W-1:0];
                CFG_RX_COST:        rx_rate       = value[COST_W-1:0];
                CFG_NOMINAL_BYTES:  nominal_bytes = value[COST_W-1:0];
                default:            ;
            endcase
        endfunction

        function logic [1:0] level_for(logic [ENERGY_W-1:0] rem);
            logic [63:0] r;
            logic [63:0] full;
            r    = 64'(rem);
            full = 64'(init_energy);
            if (r * 64'd10 >= full * 64'd9)
                return LEVEL_HIGH;
            if (r * 64'd2 >= full)
                return LEVEL_HALF;
            if (r * 64'd4 >= full)
                return LEVEL_QUARTER;
            return LEVEL_LOW;
        endfunction

        function void add_energy(logic [63:0] amount);
            logic [63:0] sum;
            sum = 64'(energy_total) + amount;
            energy_total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        endfunction

        function logic [1:0] book_request(req_t r);
            rsp_t        want;
            logic [63:0] rate;
            logic [63:0] cost;
            logic [63:0] limit;
            logic [63:0] old;
            int          id;
            want        = '0;
            want.status = STATUS_IGNORED;
            id          = int'(r.node_id);
            if (id < NODE_COUNT)
            begin
                if (r.op == OP_INSTALL)
                begin
                    budget[id]  = init_energy;
                    live[id]    = 1'b1;
                    want.status = STATUS_INSTALLED;
                end
                else if ((r.op == OP_TX || r.op == OP_RX) && live[id])
                begin
                    rate  = (r.op == OP_TX) ? 64'(tx_rate) : 64'(rx_rate);
                    cost  = 64'(r.packet_bytes) * rate;
                    limit = 64'(nominal_bytes) * rate;
                    old   = 64'(budget[id]);
                    if (old <= cost + limit)
                    begin
                        budget[id] = '0;
                        live[id]   = 1'b0;
                        add_energy(old);
                        if (!drain_seen)
                        begin
                            drain_seen  = 1'b1;
                            first_drain = r.node_id;
                        end
                        if (drain_tally != TALLY_MAX)
                            drain_tally = drain_tally + TALLY_W'(1);
                        want.stop_request = r.node_is_sink;
                        want.status       = STATUS_DRAINED;
                    end
                    else
                    begin
                        budget[id] = ENERGY_W'(old - cost);
                        add_energy(cost);
                        want.status = STATUS_CHARGED;
                    end
                end
                want.remaining = budget[id];
            end
            want.level              = level_for(want.remaining);
            want.can_send           = 64'(want.remaining) >= 64'(r.packet_bytes) * 64'(tx_rate);
            want.drained_count      = drain_tally;
            want.first_drained_node = first_drain;
            want.any_drained        = drain_seen;
            want.total_consumed     = energy_total;
            due_reports.push_back(want);
            return want.status;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void match_report(rsp_t got);
            rsp_t want;
            if (due_reports.size() == 0)
            begin
                $error("result with nothing pending: status %0d, remaining %0d",
                       got.status, got.remaining);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("remaining", 64'(want.remaining), 64'(got.remaining));
            compare_field("level", 64'(want.level), 64'(got.level));
            compare_field("can_send", 64'(want.can_send), 64'(got.can_send));
            compare_field("stop_request", 64'(want.stop_request),
                          64'(got.stop_request));
            compare_field("drained_count", 64'(want.drained_count),
                          64'(got.drained_count));
            compare_field("first_drained_node", 64'(want.first_drained_node),
                          64'(got.first_drained_node));
            compare_field("any_drained", 64'(want.any_drained), 64'(got.any_drained));
            compare_field("total_consumed", 64'(want.total_consumed),
                          64'(got.total_consumed));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_t                   req;
    logic                   rsp_valid;
    logic                   rsp_stall;
    rsp_t                   rsp;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ENERGY_W-1:0]    cfg_data;

    budget_ledger ledger;
    bit           req_quiet;
    bit           rsp_quiet;
    logic [1:0]   last_outcome;
    int           idle_cycles = 0;

    per_node_energy_budget_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic req_t make_event(logic [1:0] op, logic [NODE_ID_W-1:0] node,
                                        logic [COST_W-1:0] bytes, logic sink);
        req_t r;
        r.op           = op;
        r.node_id      = node;
        r.packet_bytes = bytes;
        r.node_is_sink = sink;
        return r;
    endfunction

    function automatic logic [COST_W-1:0] pick_bytes();
        case ($urandom_range(0, 3))
            0:       return COST_W'($urandom_range(0, 64));
            1:       return COST_W'($urandom_range(0, 1024));
            2:       return COST_W'($urandom);
            default: return $urandom_range(0, 1) ? COST_MAX : '0;
        endcase
    endfunction

    task automatic send_event(input req_t r);
        int gap;
        gap = req_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        last_outcome = ledger.book_request(r);
    endtask

    task automatic post(logic [1:0] op, logic [NODE_ID_W-1:0] node,
                        logic [COST_W-1:0] bytes, logic sink);
        send_event(make_event(op, node, bytes, sink));
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (ledger.due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(logic [ENERGY_W-1:0] init, logic [COST_W-1:0] tx,
                                 logic [COST_W-1:0] rx, logic [COST_W-1:0] nominal);
        logic [CFG_INDEX_W-1:0] index [4];
        logic [ENERGY_W-1:0]    value [4];
        index[0] = CFG_INITIAL_ENERGY;
        index[1] = CFG_TX_COST;
        index[2] = CFG_RX_COST;
        index[3] = CFG_NOMINAL_BYTES;
        value[0] = init;
        value[1] = ENERGY_W'(tx);
        value[2] = ENERGY_W'(rx);
        value[3] = ENERGY_W'(nominal);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= index[i];
            cfg_data  <= value[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            ledger.set_register(index[i], value[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        post(OP_TX, 6'd3, 16'd100, 1'b0);
        post(OP_UNUSED, 6'd3, 16'd100, 1'b1);
        post(OP_INSTALL, 6'd0, 16'd0, 1'b0);
        post(OP_TX, 6'd0, 16'd0, 1'b0);
        post(OP_TX, 6'd0, 16'd100, 1'b0);
        post(OP_RX, 6'd0, COST_MAX, 1'b0);
        post(OP_RX, 6'd0, COST_MAX, 1'b0);
        post(OP_TX, 6'd0, COST_MAX, 1'b1);
        post(OP_RX, 6'd0, 16'd10, 1'b1);
        post(OP_INSTALL, 6'd63, COST_MAX, 1'b1);
        post(OP_TX, 6'd63, 16'd1000, 1'b1);
        post(OP_INSTALL, 6'd63, COST_MAX, 1'b1);
        post(OP_UNUSED, 6'd63, 16'd0, 1'b0);
        post(OP_INSTALL, 6'd42, 16'd1, 1'b0);
        post(OP_RX, 6'd42, COST_MAX, 1'b0);
        post(OP_RX, 6'd42, COST_MAX, 1'b0);
        post(OP_RX, 6'd42, COST_MAX, 1'b0);
        post(OP_INSTALL, 6'd0, 16'd30000, 1'b0);
        post(OP_TX, 6'd0, 16'd512, 1'b1);
        post(OP_RX, 6'd21, COST_MAX, 1'b1);
    endtask

    task automatic run_traffic(int target);
        int                   counted;
        int                   charges;
        logic [NODE_ID_W-1:0] node;
        logic                 sink;
        counted = 0;
        while (counted < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                post(2'($urandom_range(0, 3)), NODE_ID_W'($urandom_range(0, NODE_COUNT - 1)),
                     pick_bytes(), 1'($urandom_range(0, 1)));
                counted++;
            end
            else
            begin
                node = NODE_ID_W'($urandom_range(0, NODE_COUNT - 1));
                sink = 1'($urandom_range(0, 1));
                post(OP_INSTALL, node, pick_bytes(), sink);
                charges = $urandom_range(1, 6);
                counted = counted + charges + 1;
                repeat (charges)
                begin
                    post($urandom_range(0, 1) ? OP_RX : OP_TX, node, pick_bytes(), sink);
                end
            end
        end
    endtask

    task automatic run_phase(logic [ENERGY_W-1:0] init, logic [COST_W-1:0] tx,
                             logic [COST_W-1:0] rx, logic [COST_W-1:0] nominal);
        settle();
        load_settings(init, tx, rx, nominal);
        req_quiet = ($urandom_range(0, 3) == 0);
        rsp_quiet = ($urandom_range(0, 3) == 0);
        run_traffic(PHASE_ITEMS);
    endtask

    // Install and drain nodes one after another until the drain count
    // saturates, then a little beyond.
    task automatic run_saturation();
        logic [NODE_ID_W-1:0] node;
        int                   extra;
        node  = '0;
        extra = 0;
        while (extra < SATURATED_RUN)
        begin
            if (ledger.drain_tally == TALLY_MAX)
                extra++;
            if (!ledger.live[node])
                post(OP_INSTALL, node, COST_MAX, node[0]);
            else
            begin
                post(OP_TX, node, COST_MAX, node[0]);
                if (last_outcome == STATUS_DRAINED)
                    node = node + NODE_ID_W'(1);
            end
        end
    endtask

    initial
    begin
        int gap;
        rsp_stall <= 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rsp_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                ledger.match_report(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_per_node_energy_budget_tracker_unit: done, errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        ledger = new();
        req_quiet = 1'b0;
        rsp_quiet = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(INITIAL_ENERGY_RESET, TX_COST_RESET, RX_COST_RESET, NOMINAL_BYTES_RESET);
        run_phase(40'd50000000, 16'd1000, 16'd500, 16'd64);
        run_phase(ENERGY_MAX, COST_MAX, COST_MAX, COST_MAX);
        run_phase('0, '0, '0, '0);
        repeat (2)
            run_phase(ENERGY_W'({$urandom, $urandom}) >> $urandom_range(8, 30),
                      COST_W'($urandom_range(0, 65535) >> $urandom_range(0, 12)),
                      COST_W'($urandom_range(0, 65535) >> $urandom_range(0, 12)),
                      COST_W'($urandom_range(0, 1024)));

        settle();
        load_settings(40'd5000000, COST_MAX, COST_MAX, '0);
        req_quiet = 1'b1;
        rsp_quiet = 1'b1;
        run_saturation();
        settle();

        if (ledger.errors == 0)
            $display("tb_per_node_energy_budget_tracker_unit: done, clean");
        else
            $display("tb_per_node_energy_budget_tracker_unit: done, errors");
        $finish;
    end

endmodule

>>> per_node_energy_budget_tracker_unit.f
design/pnebt_pkg.sv
design/pnebt_ram.sv
design/pnebt_ctrl.sv
design/pnebt_dp.sv
design/per_node_energy_budget_tracker_unit.sv
tb/sv/tb_per_node_energy_budget_tracker_unit.sv
